/* hdl/mcue_pkg.sv */
// Package for the upwind Markov-chain expectation block.
// Holds shared widths, register indexes, the queued item type and the config type.
// No dependencies.
package mcue_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int DATA_W       = 32;
  localparam int SPC_W        = 31;
  localparam int RATE_W       = 48;
  localparam int DIM_W        = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int DEF_MAX_DIMS = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SPACING_0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING_1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING_2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING_3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPACING = 3'd4;

  localparam logic [SPC_W-1:0] ONE_SPC = SPC_W'(1 << FRAC_BITS);
  localparam logic [SPC_W-1:0] MAX31   = {SPC_W{1'b1}};

  typedef struct packed {
    logic signed [DATA_W-1:0] drift;
    logic signed [DATA_W-1:0] diffusion;
    logic                     use_minus;
    logic                     use_plus;
    logic signed [DATA_W-1:0] cost_minus;
    logic signed [DATA_W-1:0] cost_plus;
    logic signed [DATA_W-1:0] self_cost;
    logic                     last;
    logic                     drop;
    logic [DIM_W-1:0]         dim;
  } item_t;

  typedef struct packed {
    logic [3:0][SPC_W-1:0] spacing;
    logic [SPC_W-1:0]      min_spacing;
  } cfg_t;

endpackage

/* hdl/markov_chain_upwind_expectation_top.sv */
// Upwind Markov-chain transition probabilities and expected cost for one grid node.
// One input transfer per state dimension; one result transfer on the last one.
// Takes one item at a time. A stored dimension runs through its own states and two
// divisions, each cut short when the quotient saturates. The last item adds one division
// for the time step, a pass over the neighbor slots with one division per used neighbor,
// and the finishing states; with no used neighbor those divisions are skipped. All
// divisions share one radix-2 divider. Input transfers keep flowing into a two-entry
// queue while the back end works, and a finished result waits in an output register, so
// the input side is stalled only when the queue is full. Values are signed Q16.16,
// truncating, and saturating; dimensions beyond MAX_DIMS are dropped and flagged in
// overflow_o. Write the spacing registers only while the block is idle.
module markov_chain_upwind_expectation_top import mcue_pkg::*; #(
  parameter int MAX_DIMS = DEF_MAX_DIMS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [SPC_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] drift_i,
  input  logic signed [DATA_W-1:0] diffusion_i,
  input  logic                     use_minus_i,
  input  logic                     use_plus_i,
  input  logic signed [DATA_W-1:0] cost_minus_i,
  input  logic signed [DATA_W-1:0] cost_plus_i,
  input  logic signed [DATA_W-1:0] self_cost_i,
  input  logic                     last_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] expected_cost_o,
  output logic [SPC_W-1:0]         time_step_o,
  output logic signed [DATA_W-1:0] self_probability_o,
  output logic                     overflow_o
);

  cfg_t  cfg_q;
  item_t front_item, queue_item;
  logic  push, pop, full, empty;

  // spacing registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spacing     <= {4{ONE_SPC}};
      cfg_q.min_spacing <= ONE_SPC;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SPACING_0:   cfg_q.spacing[0]  <= cfg_data_i;
        REG_SPACING_1:   cfg_q.spacing[1]  <= cfg_data_i;
        REG_SPACING_2:   cfg_q.spacing[2]  <= cfg_data_i;
        REG_SPACING_3:   cfg_q.spacing[3]  <= cfg_data_i;
        REG_MIN_SPACING: cfg_q.min_spacing <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: classify each transfer by dimension
  mcue_front #(.MAX_DIMS(MAX_DIMS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .drift_i     (drift_i),
    .diffusion_i (diffusion_i),
    .use_minus_i (use_minus_i),
    .use_plus_i  (use_plus_i),
    .cost_minus_i(cost_minus_i),
    .cost_plus_i (cost_plus_i),
    .self_cost_i (self_cost_i),
    .last_i      (last_i),
    .full_i      (full),
    .push_o      (push),
    .item_o      (front_item)
  );

  // decouple front from back
  mcue_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .full_o (full),
    .empty_o(empty),
    .item_o (queue_item)
  );

  // back: arithmetic, neighbor store, normalization, result register
  mcue_back #(.MAX_DIMS(MAX_DIMS)) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .empty_i           (empty),
    .item_i            (queue_item),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .expected_cost_o   (expected_cost_o),
    .time_step_o       (time_step_o),
    .self_probability_o(self_probability_o),
    .overflow_o        (overflow_o)
  );

endmodule

/* hdl/mcue_front.sv */
// Front end: accepts input transfers, numbers the dimension and marks surplus ones.
// Depends on mcue_pkg.
module mcue_front import mcue_pkg::*; #(
  parameter int MAX_DIMS = DEF_MAX_DIMS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] drift_i,
  input  logic signed [DATA_W-1:0] diffusion_i,
  input  logic                     use_minus_i,
  input  logic                     use_plus_i,
  input  logic signed [DATA_W-1:0] cost_minus_i,
  input  logic signed [DATA_W-1:0] cost_plus_i,
  input  logic signed [DATA_W-1:0] self_cost_i,
  input  logic                     last_i,
  input  logic                     full_i,
  output logic                     push_o,
  output item_t                    item_o
);

  localparam int CNT_W = $clog2(MAX_DIMS + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic             drop;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;
  assign drop       = (count_q == CNT_W'(MAX_DIMS));

  always_comb begin
    item_o.drift      = drift_i;
    item_o.diffusion  = diffusion_i;
    item_o.use_minus  = use_minus_i;
    item_o.use_plus   = use_plus_i;
    item_o.cost_minus = cost_minus_i;
    item_o.cost_plus  = cost_plus_i;
    item_o.self_cost  = self_cost_i;
    item_o.last       = last_i;
    item_o.drop       = drop;
    item_o.dim        = DIM_W'(count_q);
  end

  always_comb begin
    count_d = count_q;
    if (push_o) begin
      if (last_i) begin
        count_d = '0;
      end else if (!drop) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

/* hdl/mcue_queue.sv */
// Two-entry queue of classified items between front and back end.
// Depends on mcue_pkg.
module mcue_queue import mcue_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  empty_o,
  output item_t item_o
);

  item_t       mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

/* hdl/mcue_div.sv */
// Iterative unsigned divider, one quotient bit per cycle, quotient capped at 2^31-1.
// Depends on mcue_pkg.
module mcue_div import mcue_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RATE_W-1:0] num_i,
  input  logic [RATE_W-1:0] den_i,
  output logic              busy_o,
  output logic [SPC_W-1:0]  quot_o
);

  logic [RATE_W-1:0] rem_q, den_q;
  logic [SPC_W-1:0]  low_q, quot_q;
  logic [4:0]        cnt_q;
  logic              busy_q;
  logic [RATE_W:0]   rem_sh;
  logic              fits;

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_sh = {rem_q, low_q[SPC_W-1]};
  assign fits   = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      low_q <= num_i[SPC_W-1:0];
      if ({{SPC_W{1'b0}}, num_i[RATE_W-1:SPC_W]} >= den_i) begin
        quot_q <= MAX31;
      end else begin
        quot_q <= '0;
      end
      rem_q <= {{SPC_W{1'b0}}, num_i[RATE_W-1:SPC_W]};
    end else if (busy_q) begin
      low_q  <= {low_q[SPC_W-2:0], 1'b0};
      quot_q <= {quot_q[SPC_W-2:0], fits};
      rem_q  <= fits ? RATE_W'(rem_sh - {1'b0, den_q}) : rem_sh[RATE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= ({{SPC_W{1'b0}}, num_i[RATE_W-1:SPC_W]} < den_i);
      cnt_q  <= 5'(SPC_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == 5'd0) busy_q <= 1'b0;
    end
  end

endmodule

/* hdl/mcue_back.sv */
// Back end: sequencer that forms upwind probabilities, keeps the neighbor store,
// normalizes on the last dimension and holds the result register. Uses mcue_div, mcue_pkg.
module mcue_back import mcue_pkg::*; #(
  parameter int MAX_DIMS = DEF_MAX_DIMS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     empty_i,
  input  item_t                    item_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] expected_cost_o,
  output logic [SPC_W-1:0]         time_step_o,
  output logic signed [DATA_W-1:0] self_probability_o,
  output logic                     overflow_o
);

  localparam int SLOTS  = 2 * MAX_DIMS;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SUM_W  = FRAC_BITS + 2 + SLOT_W;
  localparam int ACC_W  = 40;
  localparam int MUL_W  = 2 * (DATA_W + 1);

  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(-64'sd2147483648);

  localparam logic [4:0] ST_IDLE = 5'd0,  ST_LOAD = 5'd1,  ST_A  = 5'd2,  ST_B  = 5'd3;
  localparam logic [4:0] ST_C    = 5'd4,  ST_D    = 5'd5,  ST_E  = 5'd6,  ST_F  = 5'd7;
  localparam logic [4:0] ST_G    = 5'd8,  ST_H    = 5'd9,  ST_I  = 5'd10, ST_J  = 5'd11;
  localparam logic [4:0] ST_K    = 5'd12, ST_N0   = 5'd13, ST_N1 = 5'd14, ST_N2 = 5'd15;
  localparam logic [4:0] ST_N3   = 5'd16, ST_N4   = 5'd17, ST_N5 = 5'd18, ST_N6 = 5'd19;
  localparam logic [4:0] ST_N7   = 5'd20, ST_OUT  = 5'd21;

  function automatic logic [SPC_W-1:0] cap31(input logic signed [MUL_W-1:0] v);
    if (v > $signed({{(MUL_W-SPC_W){1'b0}}, MAX31})) return MAX31;
    return v[SPC_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] frac_div(input logic signed [MUL_W-1:0] p);
    logic signed [MUL_W-1:0] a;
    a = p + (p < 0 ? MUL_W'((1 << FRAC_BITS) - 1) : MUL_W'(0));
    return ACC_W'(a >>> FRAC_BITS);
  endfunction

  logic [4:0]              state_q, state_d;
  item_t                   item_q;
  logic signed [MUL_W-1:0] mul_q;
  logic signed [DATA_W:0]  mul_a, mul_b;
  logic [SPC_W-1:0]        minh2_q, sig2_q, r_q, t_q, hrel_q, dterm_q, aterm_q;
  logic [SPC_W-1:0]        raw_q [SLOTS];
  logic signed [DATA_W-1:0] cost_q [SLOTS];
  logic [SLOTS-1:0]        used_q;
  logic [RATE_W-1:0]       rate_q;
  logic                    ovf_seen_q;
  logic [SLOT_W-1:0]       sl_q;
  logic [SUM_W-1:0]        sum_q;
  logic signed [DATA_W-1:0] selfp_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [SPC_W-1:0]        step_q;

  logic                    out_valid_q, ovf_out_q;
  logic signed [DATA_W-1:0] exp_out_q, selfp_out_q;
  logic [SPC_W-1:0]        step_out_q;

  logic                    div_start, div_busy;
  logic [RATE_W-1:0]       div_num, div_den;
  logic [SPC_W-1:0]        div_quot;

  logic [SPC_W-1:0]        h_raw, h;
  logic [DATA_W-1:0]       mag_diff, mag_drift;
  logic                    drift_pos;
  logic [DATA_W-1:0]       p_sum;
  logic [SPC_W-1:0]        p_new;
  logic                    store_en;
  logic [SLOT_W-1:0]       store_slot;
  logic [RATE_W:0]         rate_sum;
  logic                    out_load;
  logic signed [ACC_W-1:0] acc_fin;
  logic signed [DATA_W-1:0] acc_sat;

  mcue_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quot_o (div_quot)
  );

  // spacing of the current dimension; dimensions past the fourth share the last register
  assign h_raw     = cfg_i.spacing[(item_q.dim > DIM_W'(3)) ? 2'd3 : item_q.dim[1:0]];
  assign h         = (h_raw == '0) ? SPC_W'(1) : h_raw;
  assign mag_diff  = item_q.diffusion[DATA_W-1] ? DATA_W'(-item_q.diffusion)
                                                : DATA_W'(item_q.diffusion);
  assign mag_drift = item_q.drift[DATA_W-1] ? DATA_W'(-item_q.drift) : DATA_W'(item_q.drift);
  assign drift_pos = !item_q.drift[DATA_W-1] && (item_q.drift != '0);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_LOAD: begin
        mul_a = {2'b00, cfg_i.min_spacing};
        mul_b = {2'b00, cfg_i.min_spacing};
      end
      ST_A: begin
        mul_a = {1'b0, mag_diff};
        mul_b = {1'b0, mag_diff};
      end
      ST_D: begin
        mul_a = {2'b00, r_q};
        mul_b = {2'b00, r_q};
      end
      ST_G: begin
        mul_a = {2'b00, t_q};
        mul_b = {2'b00, sig2_q};
      end
      ST_H: begin
        mul_a = {2'b00, hrel_q};
        mul_b = {1'b0, mag_drift};
      end
      ST_N3: begin
        mul_a = {{(DATA_W-FRAC_BITS){1'b0}}, div_quot[FRAC_BITS:0]};
        mul_b = {cost_q[sl_q][DATA_W-1], cost_q[sl_q]};
      end
      ST_N6: begin
        mul_a = {selfp_q[DATA_W-1], selfp_q};
        mul_b = {item_q.self_cost[DATA_W-1], item_q.self_cost};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider launch
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_q)
      ST_A: begin
        div_start = 1'b1;
        div_num   = RATE_W'({cfg_i.min_spacing, {FRAC_BITS{1'b0}}});
        div_den   = RATE_W'(h);
      end
      ST_C: begin
        div_start = !div_busy;
        div_num   = RATE_W'({minh2_q, {FRAC_BITS{1'b0}}});
        div_den   = RATE_W'(h);
      end
      ST_N0: begin
        div_start = (rate_q != '0);
        div_num   = RATE_W'({minh2_q, {FRAC_BITS{1'b0}}});
        div_den   = rate_q;
      end
      ST_N2: begin
        div_start = used_q[sl_q];
        div_num   = RATE_W'({raw_q[sl_q], {FRAC_BITS{1'b0}}});
        div_den   = rate_q;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // neighbor store write: minus side in ST_J, plus side in ST_K
  always_comb begin
    store_en   = 1'b0;
    store_slot = SLOT_W'({item_q.dim, 1'b0});
    p_sum      = {1'b0, dterm_q};
    if (state_q == ST_J) begin
      store_en = item_q.use_minus;
      if (!drift_pos) p_sum = {1'b0, dterm_q} + {1'b0, aterm_q};
    end else if (state_q == ST_K) begin
      store_en   = item_q.use_plus;
      store_slot = SLOT_W'({item_q.dim, 1'b1});
      if (drift_pos) p_sum = {1'b0, dterm_q} + {1'b0, aterm_q};
    end
    p_new    = p_sum[DATA_W-1] ? MAX31 : p_sum[SPC_W-1:0];
    rate_sum = {1'b0, rate_q} + (RATE_W + 1)'(p_new);
  end

  assign pop_o    = (state_q == ST_IDLE) && !empty_i;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  assign acc_fin = acc_q + (((state_q == ST_N7) && (selfp_q > 0)) ? frac_div(mul_q) : '0);
  assign acc_sat = (acc_fin > ACC_HI) ? 32'sh7FFFFFFF :
                   (acc_fin < ACC_LO) ? 32'sh80000000 : acc_fin[DATA_W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (!empty_i) state_d = ST_LOAD;
      ST_LOAD: state_d = item_q.drop ? (item_q.last ? ST_N0 : ST_IDLE) : ST_A;
      ST_A:    state_d = ST_B;
      ST_B:    state_d = ST_C;
      ST_C:    if (!div_busy) state_d = ST_D;
      ST_D:    state_d = ST_E;
      ST_E:    state_d = ST_F;
      ST_F:    if (!div_busy) state_d = ST_G;
      ST_G:    state_d = ST_H;
      ST_H:    state_d = ST_I;
      ST_I:    state_d = ST_J;
      ST_J:    state_d = ST_K;
      ST_K:    state_d = item_q.last ? ST_N0 : ST_IDLE;
      ST_N0:   state_d = (rate_q != '0) ? ST_N1 : ST_N5;
      ST_N1:   if (!div_busy) state_d = ST_N2;
      ST_N2: begin
        if (used_q[sl_q]) begin
          state_d = ST_N3;
        end else if (sl_q == SLOT_W'(SLOTS - 1)) begin
          state_d = ST_N5;
        end
      end
      ST_N3:   if (!div_busy) state_d = ST_N4;
      ST_N4:   state_d = (sl_q == SLOT_W'(SLOTS - 1)) ? ST_N5 : ST_N2;
      ST_N5:   state_d = ST_N6;
      ST_N6:   state_d = ST_N7;
      ST_N7:   state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    if (pop_o) item_q <= item_i;
    case (state_q)
      ST_A: minh2_q <= cap31(mul_q >>> FRAC_BITS);
      ST_B: sig2_q  <= cap31(mul_q >>> FRAC_BITS);
      ST_C: if (!div_busy) r_q <= div_quot;
      ST_E: t_q     <= cap31(mul_q >>> FRAC_BITS);
      ST_F: if (!div_busy) hrel_q <= div_quot;
      ST_H: dterm_q <= cap31(mul_q >>> (FRAC_BITS + 1));
      ST_I: aterm_q <= cap31(mul_q >>> FRAC_BITS);
      ST_N0: begin
        sum_q  <= '0;
        acc_q  <= '0;
        step_q <= '0;
        sl_q   <= '0;
      end
      ST_N1: if (!div_busy) step_q <= div_quot;
      ST_N2: if (!used_q[sl_q] && (sl_q != SLOT_W'(SLOTS - 1))) sl_q <= sl_q + 1'b1;
      ST_N3: if (!div_busy) sum_q <= sum_q + SUM_W'(div_quot[FRAC_BITS:0]);
      ST_N4: begin
        acc_q <= acc_q + frac_div(mul_q);
        if (sl_q != SLOT_W'(SLOTS - 1)) sl_q <= sl_q + 1'b1;
      end
      ST_N5: selfp_q <= DATA_W'(1 << FRAC_BITS) - DATA_W'(sum_q);
      ST_N7: acc_q   <= acc_fin;
      default: ;
    endcase
    if (store_en) begin
      raw_q[store_slot]  <= p_new;
      cost_q[store_slot] <= (state_q == ST_J) ? item_q.cost_minus : item_q.cost_plus;
    end
    if (out_load) begin
      exp_out_q   <= acc_sat;
      step_out_q  <= step_q;
      selfp_out_q <= selfp_q;
      ovf_out_q   <= ovf_seen_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      rate_q      <= '0;
      ovf_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (store_en) begin
        used_q[store_slot] <= 1'b1;
        rate_q <= rate_sum[RATE_W] ? {RATE_W{1'b1}} : rate_sum[RATE_W-1:0];
      end
      if ((state_q == ST_LOAD) && item_q.drop) ovf_seen_q <= 1'b1;
      if (out_load) begin
        used_q     <= '0;
        rate_q     <= '0;
        ovf_seen_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign expected_cost_o    = exp_out_q;
  assign time_step_o        = step_out_q;
  assign self_probability_o = selfp_out_q;
  assign overflow_o         = ovf_out_q;

endmodule

/* dv/markov_chain_upwind_expectation_top_tb.sv */
// Testbench for markov_chain_upwind_expectation_top: directed and random grid nodes.
// Predicts each node result in a scoreboard class and checks every output transfer.
// Depends on mcue_pkg and the block's RTL.
module markov_chain_upwind_expectation_top_tb;
  import mcue_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] drift;
    logic signed [DATA_W-1:0] diffusion;
    logic                     use_minus;
    logic                     use_plus;
    logic signed [DATA_W-1:0] cost_minus;
    logic signed [DATA_W-1:0] cost_plus;
    logic signed [DATA_W-1:0] self_cost;
    logic                     last;
  } dim_item_t;

  typedef struct {
    logic signed [DATA_W-1:0] cost;
    logic [SPC_W-1:0]         step;
    logic signed [DATA_W-1:0] self_p;
    logic                     ovf;
  } node_result_t;

  localparam longint SAT31    = 64'h7FFF_FFFF;
  localparam longint RATE_SAT = (64'sd1 <<< RATE_W) - 1;
  localparam longint ONE_FX   = 64'sd1 <<< FRAC_BITS;
  localparam int     SLOTS    = 2 * DEF_MAX_DIMS;

  // Upwind transition predictor and store of pending node results.
  class node_scoreboard;
    longint spacing[4];
    longint min_spc;
    longint raw_p[SLOTS];
    longint nb_cost[SLOTS];
    bit     nb_used[SLOTS];
    longint rate;
    int     dims;
    bit     ovf_seen;
    node_result_t pending_results[$];
    int     errors;

    function void clear_node();
      for (int i = 0; i < SLOTS; i++) begin
        raw_p[i] = 0;
        nb_cost[i] = 0;
        nb_used[i] = 0;
      end
      rate = 0;
      dims = 0;
      ovf_seen = 0;
    endfunction

    function new();
      for (int i = 0; i < 4; i++) spacing[i] = ONE_FX;
      min_spc = ONE_FX;
      errors = 0;
      clear_node();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SPC_W-1:0] val);
      if (idx == REG_MIN_SPACING) min_spc = val;
      else if (idx <= REG_SPACING_3) spacing[idx] = val;
    endfunction

    function longint sat(longint v, longint hi);
      return v > hi ? hi : v;
    endfunction

    function longint absval(longint v);
      return v < 0 ? -v : v;
    endfunction

    function void put_neighbor(int slot, longint p, longint c);
      raw_p[slot] = p;
      nb_cost[slot] = c;
      nb_used[slot] = 1;
      rate = sat(rate + p, RATE_SAT);
    endfunction

    // Advance the node state with one accepted dimension; queue a result on last.
    function void note_input(dim_item_t it);
      longint minh2, h, mag, sig2, r, t, hrel, dterm, aterm, drift;
      longint step, self_p, acc, sum, pn;
      node_result_t res;
      minh2 = sat((min_spc * min_spc) >>> FRAC_BITS, SAT31);
      drift = it.drift;
      if (dims < DEF_MAX_DIMS) begin
        h = spacing[dims < 4 ? dims : 3];
        if (h == 0) h = 1;
        mag = absval(longint'(it.diffusion));
        sig2 = sat((mag * mag) >>> FRAC_BITS, SAT31);
        r = sat((min_spc <<< FRAC_BITS) / h, SAT31);
        t = sat((r * r) >>> FRAC_BITS, SAT31);
        hrel = sat((minh2 <<< FRAC_BITS) / h, SAT31);
        dterm = sat((t * sig2) >>> (FRAC_BITS + 1), SAT31);
        aterm = sat((hrel * absval(drift)) >>> FRAC_BITS, SAT31);
        if (it.use_minus)
          put_neighbor(2 * dims, sat(dterm + (drift <= 0 ? aterm : 0), SAT31), it.cost_minus);
        if (it.use_plus)
          put_neighbor(2 * dims + 1, sat(dterm + (drift > 0 ? aterm : 0), SAT31), it.cost_plus);
        dims++;
      end else begin
        ovf_seen = 1;
      end
      if (!it.last) return;
      step = 0;
      self_p = ONE_FX;
      acc = 0;
      if (rate != 0) begin
        sum = 0;
        step = sat((minh2 <<< FRAC_BITS) / rate, SAT31);
        for (int i = 0; i < SLOTS; i++) begin
          if (nb_used[i]) begin
            pn = (raw_p[i] <<< FRAC_BITS) / rate;
            sum += pn;
            acc += (pn * nb_cost[i]) / ONE_FX;
          end
        end
        self_p = ONE_FX - sum;
      end
      // self cost counts only when the node keeps some probability of staying
      if (self_p > 0) acc += (self_p * longint'(it.self_cost)) / ONE_FX;
      if (acc > SAT31) acc = SAT31;
      if (acc < -SAT31 - 1) acc = -SAT31 - 1;
      res.cost = acc[31:0];
      res.step = step[30:0];
      res.self_p = self_p[31:0];
      res.ovf = ovf_seen;
      pending_results.push_back(res);
      clear_node();
    endfunction

    function void check_result(logic signed [DATA_W-1:0] cost, logic [SPC_W-1:0] step,
                               logic signed [DATA_W-1:0] self_p, logic ovf);
      node_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result cost=%0d step=%0d self_p=%0d ovf=%0b",
                 $time, cost, step, self_p, ovf);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (cost !== e.cost) begin
        $display("%0t: expected_cost expected %0d actual %0d", $time, e.cost, cost);
        errors++;
      end
      if (step !== e.step) begin
        $display("%0t: time_step expected %0d actual %0d", $time, e.step, step);
        errors++;
      end
      if (self_p !== e.self_p) begin
        $display("%0t: self_probability expected %0d actual %0d", $time, e.self_p, self_p);
        errors++;
      end
      if (ovf !== e.ovf) begin
        $display("%0t: overflow expected %0b actual %0b", $time, e.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_idx_i;
  logic [SPC_W-1:0]         cfg_data_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] drift_i, diffusion_i, cost_minus_i, cost_plus_i, self_cost_i;
  logic                     use_minus_i, use_plus_i, last_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [DATA_W-1:0] expected_cost_o, self_probability_o;
  logic [SPC_W-1:0]         time_step_o;
  logic                     overflow_o;

  node_scoreboard sb = new();
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int items_sent = 0;

  markov_chain_upwind_expectation_top i_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver: check each result transfer, then pick the stall for the next cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i)
        sb.check_result(expected_cost_o, time_step_o, self_probability_o, overflow_o);
      out_stall_i <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // Hold valid and payload until the transfer; idle gaps drop valid first.
  task automatic send_dim(dim_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    drift_i      <= it.drift;
    diffusion_i  <= it.diffusion;
    use_minus_i  <= it.use_minus;
    use_plus_i   <= it.use_plus;
    cost_minus_i <= it.cost_minus;
    cost_plus_i  <= it.cost_plus;
    self_cost_i  <= it.self_cost;
    last_i       <= it.last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(it);
    items_sent++;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3, 4: return $urandom;
      default: return $urandom_range(32'h3_FFFF) - 32'h2_0000;
    endcase
  endfunction

  function automatic dim_item_t random_dim(bit is_last);
    dim_item_t it;
    it.drift      = pick_value();
    it.diffusion  = pick_value();
    it.use_minus  = $urandom_range(3) != 0;
    it.use_plus   = $urandom_range(3) != 0;
    it.cost_minus = pick_value();
    it.cost_plus  = pick_value();
    it.self_cost  = pick_value();
    it.last       = is_last;
    return it;
  endfunction

  // Send one node; mostly within MAX_DIMS, sometimes past it to hit overflow.
  task automatic send_node();
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(DEF_MAX_DIMS + 1, DEF_MAX_DIMS + 2)
                                 : $urandom_range(1, DEF_MAX_DIMS);
    for (int d = 0; d < n; d++) send_dim(random_dim(d == n - 1));
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [SPC_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic set_spacing(logic [SPC_W-1:0] s0, s1, s2, s3, mn);
    cfg_write(REG_SPACING_0, s0);
    cfg_write(REG_SPACING_1, s1);
    cfg_write(REG_SPACING_2, s2);
    cfg_write(REG_SPACING_3, s3);
    cfg_write(REG_MIN_SPACING, mn);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drain: stop sending, wait for every result, then let the back end settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic logic [SPC_W-1:0] rand_spc(bit near_one);
    if (near_one) return SPC_W'($urandom_range(32'h4_0000, 32'h8000));
    return SPC_W'($urandom_range(32'h7FFF_FFFF, 1));
  endfunction

  initial begin
    dim_item_t it;
    logic [SPC_W-1:0] s[4];
    logic [SPC_W-1:0] mn;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_SPACING_0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    drift_i = '0;
    diffusion_i = '0;
    use_minus_i = 1'b0;
    use_plus_i = 1'b0;
    cost_minus_i = '0;
    cost_plus_i = '0;
    self_cost_i = '0;
    last_i = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero rate: no neighbor at all, self cost passes through.
    it = '{32'sh1_0000, 32'sh1_0000, 1'b0, 1'b0, 32'sh5, 32'sh6, 32'sh7FFF_FFFF, 1'b1};
    send_dim(it);
    it.self_cost = 32'sh8000_0000;
    send_dim(it);
    // Single neighbor: self probability ends at zero, self cost dropped.
    it = '{32'sh0, 32'sh2_0000, 1'b1, 1'b0, 32'sh3_0000, 32'sh0, 32'sh7FFF_FFFF, 1'b1};
    send_dim(it);
    // Extremes of drift, diffusion and costs over a full node.
    it = '{32'sh8000_0000, 32'sh8000_0000, 1'b1, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000,
           32'sh0, 1'b0};
    send_dim(it);
    it = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF,
           32'sh0, 1'b0};
    send_dim(it);
    it = '{32'sh0, 32'sh0, 1'b1, 1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0, 1'b0};
    send_dim(it);
    it = '{-32'sh1, 32'sh1, 1'b1, 1'b1, 32'sh1_0000, -32'sh1_0000, 32'sh4_0000, 1'b1};
    send_dim(it);
    // Too many dimensions: the fifth and sixth are dropped and flagged.
    for (int d = 0; d < 6; d++) begin
      it = '{32'sh1_8000, -32'sh8000, 1'b1, 1'b1, 32'sh1_0000, 32'sh2_0000,
             32'sh3_0000, d == 5};
      if (d >= 4) it.use_minus = 1'b0;
      send_dim(it);
    end
    // Small diffusion, only the drift term matters.
    it = '{-32'sh2_0000, 32'sh0, 1'b1, 1'b1, 32'sh1_0000, 32'sh9_0000, 32'sh1, 1'b1};
    send_dim(it);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1: set_spacing(31'd1, 31'd1, 31'd1, 31'd1, 31'd1);
          2: set_spacing(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                         31'h7FFF_FFFF);
          3, 5: begin
            foreach (s[i]) s[i] = rand_spc(1'b1);
            mn = s[0];
            foreach (s[i]) if (s[i] < mn) mn = s[i];
            set_spacing(s[0], s[1], s[2], s[3], mn);
          end
          default: begin
            foreach (s[i]) s[i] = rand_spc(1'b0);
            set_spacing(s[0], s[1], 31'd1, s[3], 31'h7FFF_FFFF);
          end
        endcase
      end
      case (ph % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 52; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 52; end
        default: begin in_idle_pct = 36; out_stall_pct = 36; end
      endcase
      while (items_sent < (ph + 1) * 217) send_node();
    end
    in_idle_pct = 0;
    out_stall_pct = 0;
    drain();

    if (sb.errors == 0) begin
      $display("** markov_chain_upwind_expectation_top: PASSED **");
    end else begin
      $display("** markov_chain_upwind_expectation_top: FAILED **");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #8000000;
    $display("** markov_chain_upwind_expectation_top: FAILED **");
    $finish;
  end

endmodule
